// ----- rtl/jhep_pkg.sv -----
// Shared types, constants and Huffman table builder for the entropy packer.
`default_nettype none
package jhep_pkg;

	localparam int CW_W        = 27;   // longest code (16) plus longest magnitude (11)
	localparam int LEN_W       = 5;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	localparam int TAB_YDC = 0;
	localparam int TAB_CDC = 1;
	localparam int TAB_YAC = 2;
	localparam int TAB_CAC = 3;

	localparam logic       CMD_CODE = 1'b0;
	localparam logic       CMD_FLUSH = 1'b1;
	localparam logic [7:0] SYM_ZRL  = 8'hF0;
	localparam logic [7:0] SYM_EOB  = 8'h00;
	localparam logic [7:0] BYTE_FF  = 8'hFF;
	localparam logic [7:0] BYTE_00  = 8'h00;

	// One unit of work for the bit packer: a right-aligned bit string.
	typedef struct packed {
		logic [CW_W-1:0]  cw;
		logic [LEN_W-1:0] len;
		logic             flush;
		logic             last;
	} op_t;

	typedef struct packed {
		logic [4:0]  len;
		logic [15:0] code;
	} hent_t;

	typedef hent_t [255:0] htab_t;

	localparam logic [0:15][7:0] YDC_BITS = '{8'd0, 8'd1, 8'd5, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1,
		8'd1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
	localparam logic [0:15][7:0] CDC_BITS = '{8'd0, 8'd3, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1,
		8'd1, 8'd1, 8'd1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
	localparam logic [0:15][7:0] YAC_BITS = '{8'd0, 8'd2, 8'd1, 8'd3, 8'd3, 8'd2, 8'd4, 8'd3,
		8'd5, 8'd5, 8'd4, 8'd4, 8'd0, 8'd0, 8'd1, 8'h7d};
	localparam logic [0:15][7:0] CAC_BITS = '{8'd0, 8'd2, 8'd1, 8'd2, 8'd4, 8'd4, 8'd3, 8'd4,
		8'd7, 8'd5, 8'd4, 8'd4, 8'd0, 8'd1, 8'd2, 8'h77};

	localparam logic [0:161][7:0] YAC_VALS = '{
		8'h01,8'h02,8'h03,8'h00,8'h04,8'h11,8'h05,8'h12,8'h21,8'h31,8'h41,8'h06,8'h13,8'h51,
		8'h61,8'h07,8'h22,8'h71,8'h14,8'h32,8'h81,8'h91,8'ha1,8'h08,8'h23,8'h42,8'hb1,8'hc1,
		8'h15,8'h52,8'hd1,8'hf0,8'h24,8'h33,8'h62,8'h72,8'h82,8'h09,8'h0a,8'h16,8'h17,8'h18,
		8'h19,8'h1a,8'h25,8'h26,8'h27,8'h28,8'h29,8'h2a,8'h34,8'h35,8'h36,8'h37,8'h38,8'h39,
		8'h3a,8'h43,8'h44,8'h45,8'h46,8'h47,8'h48,8'h49,8'h4a,8'h53,8'h54,8'h55,8'h56,8'h57,
		8'h58,8'h59,8'h5a,8'h63,8'h64,8'h65,8'h66,8'h67,8'h68,8'h69,8'h6a,8'h73,8'h74,8'h75,
		8'h76,8'h77,8'h78,8'h79,8'h7a,8'h83,8'h84,8'h85,8'h86,8'h87,8'h88,8'h89,8'h8a,8'h92,
		8'h93,8'h94,8'h95,8'h96,8'h97,8'h98,8'h99,8'h9a,8'ha2,8'ha3,8'ha4,8'ha5,8'ha6,8'ha7,
		8'ha8,8'ha9,8'haa,8'hb2,8'hb3,8'hb4,8'hb5,8'hb6,8'hb7,8'hb8,8'hb9,8'hba,8'hc2,8'hc3,
		8'hc4,8'hc5,8'hc6,8'hc7,8'hc8,8'hc9,8'hca,8'hd2,8'hd3,8'hd4,8'hd5,8'hd6,8'hd7,8'hd8,
		8'hd9,8'hda,8'he1,8'he2,8'he3,8'he4,8'he5,8'he6,8'he7,8'he8,8'he9,8'hea,8'hf1,8'hf2,
		8'hf3,8'hf4,8'hf5,8'hf6,8'hf7,8'hf8,8'hf9,8'hfa};

	localparam logic [0:161][7:0] CAC_VALS = '{
		8'h00,8'h01,8'h02,8'h03,8'h11,8'h04,8'h05,8'h21,8'h31,8'h06,8'h12,8'h41,8'h51,8'h07,
		8'h61,8'h71,8'h13,8'h22,8'h32,8'h81,8'h08,8'h14,8'h42,8'h91,8'ha1,8'hb1,8'hc1,8'h09,
		8'h23,8'h33,8'h52,8'hf0,8'h15,8'h62,8'h72,8'hd1,8'h0a,8'h16,8'h24,8'h34,8'he1,8'h25,
		8'hf1,8'h17,8'h18,8'h19,8'h1a,8'h26,8'h27,8'h28,8'h29,8'h2a,8'h35,8'h36,8'h37,8'h38,
		8'h39,8'h3a,8'h43,8'h44,8'h45,8'h46,8'h47,8'h48,8'h49,8'h4a,8'h53,8'h54,8'h55,8'h56,
		8'h57,8'h58,8'h59,8'h5a,8'h63,8'h64,8'h65,8'h66,8'h67,8'h68,8'h69,8'h6a,8'h73,8'h74,
		8'h75,8'h76,8'h77,8'h78,8'h79,8'h7a,8'h82,8'h83,8'h84,8'h85,8'h86,8'h87,8'h88,8'h89,
		8'h8a,8'h92,8'h93,8'h94,8'h95,8'h96,8'h97,8'h98,8'h99,8'h9a,8'ha2,8'ha3,8'ha4,8'ha5,
		8'ha6,8'ha7,8'ha8,8'ha9,8'haa,8'hb2,8'hb3,8'hb4,8'hb5,8'hb6,8'hb7,8'hb8,8'hb9,8'hba,
		8'hc2,8'hc3,8'hc4,8'hc5,8'hc6,8'hc7,8'hc8,8'hc9,8'hca,8'hd2,8'hd3,8'hd4,8'hd5,8'hd6,
		8'hd7,8'hd8,8'hd9,8'hda,8'he2,8'he3,8'he4,8'he5,8'he6,8'he7,8'he8,8'he9,8'hea,8'hf2,
		8'hf3,8'hf4,8'hf5,8'hf6,8'hf7,8'hf8,8'hf9,8'hfa};

	// Expands a canonical table into a code and length per symbol.
	// Only evaluated at elaboration.
	function automatic htab_t build_tab(input int sel);
		htab_t      t;
		int         k;
		int         c;
		int         nb;
		logic [7:0] sym;
		t = '0;
		k = 0;
		c = 0;
		for (int len = 1; len <= 16; len++) begin
			unique case (sel)
				TAB_YDC: nb = int'(YDC_BITS[len-1]);
				TAB_CDC: nb = int'(CDC_BITS[len-1]);
				TAB_YAC: nb = int'(YAC_BITS[len-1]);
				default: nb = int'(CAC_BITS[len-1]);
			endcase
			for (int j = 0; j < nb; j++) begin
				unique case (sel)
					TAB_YDC, TAB_CDC: sym = 8'(k);
					TAB_YAC:          sym = YAC_VALS[k];
					default:          sym = CAC_VALS[k];
				endcase
				t[sym].len  = 5'(len);
				t[sym].code = 16'(c);
				k++;
				c++;
			end
			c = c << 1;
		end
		return t;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/jhep_front.sv -----
// Front end: takes items, tracks block state, turns each into packer ops.
`default_nettype none
module jhep_front #(
	parameter int COEF_WIDTH = 11
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic                  cmd,
	input  wire logic [COEF_WIDTH-1:0] coefficient,
	input  wire logic [1:0]            component,
	output logic                       op_valid,
	input  wire logic                  op_ready,
	output jhep_pkg::op_t              op
);

	localparam jhep_pkg::htab_t YDC = jhep_pkg::build_tab(jhep_pkg::TAB_YDC);
	localparam jhep_pkg::htab_t CDC = jhep_pkg::build_tab(jhep_pkg::TAB_CDC);
	localparam jhep_pkg::htab_t YAC = jhep_pkg::build_tab(jhep_pkg::TAB_YAC);
	localparam jhep_pkg::htab_t CAC = jhep_pkg::build_tab(jhep_pkg::TAB_CAC);

	logic                         busy_q;
	logic [1:0]                   zrl_q;
	logic                         luma_q;
	jhep_pkg::op_t                main_q;
	logic signed [COEF_WIDTH-1:0] pred_q [3];
	logic [5:0]                   pos_q;
	logic [5:0]                   zrun_q;

	logic               accept;
	logic [1:0]         comp;
	logic               luma;
	logic               is_dc;
	logic               is_zero;
	logic signed [12:0] cx;
	logic signed [12:0] px;
	logic signed [12:0] diff;
	logic signed [12:0] val;
	logic [11:0]        mag_abs;
	logic [3:0]         sz;
	logic [12:0]        valm1;
	logic [10:0]        mag;
	logic [7:0]         sym;
	jhep_pkg::hent_t    ent;
	logic               emit;
	jhep_pkg::op_t      main_d;
	jhep_pkg::hent_t    zrl_ent;

	assign in_ready = !busy_q;
	assign accept   = in_valid && in_ready;

	always_comb begin
		comp    = (component == 2'd3) ? 2'd2 : component;
		luma    = (comp == 2'd0);
		is_dc   = (pos_q == 6'd0);
		cx      = 13'($signed(coefficient));
		px      = 13'(pred_q[comp]);
		is_zero = (cx == 13'sd0);
		diff    = cx - px;
		if (is_dc) begin
			if (diff > 13'sd2047)
				val = 13'sd2047;
			else if (diff < -13'sd2047)
				val = -13'sd2047;
			else
				val = diff;
		end else begin
			if (cx > 13'sd1023)
				val = 13'sd1023;
			else if (cx < -13'sd1023)
				val = -13'sd1023;
			else
				val = cx;
		end
		mag_abs = val[12] ? 12'(-val) : 12'(val);
		sz = 4'd0;
		for (int i = 0; i < 11; i++) begin
			if (mag_abs[i])
				sz = 4'(i + 1);
		end
		valm1 = (val > 13'sd0) ? 13'(val) : 13'(val - 13'sd1);
		mag   = valm1[10:0] & 11'((12'd1 << sz) - 12'd1);
		if (is_dc)
			sym = {4'd0, sz};
		else if (is_zero)
			sym = jhep_pkg::SYM_EOB;
		else
			sym = {zrun_q[3:0], sz};
		priority if (is_dc)
			ent = luma ? YDC[sym] : CDC[sym];
		else
			ent = luma ? YAC[sym] : CAC[sym];
		emit = is_dc || !is_zero || (pos_q == 6'd63);
		main_d.cw    = (jhep_pkg::CW_W'(ent.code) << sz) | jhep_pkg::CW_W'(mag);
		main_d.len   = emit ? (ent.len + jhep_pkg::LEN_W'(sz)) : '0;
		main_d.flush = 1'b0;
		main_d.last  = 1'b1;
		if (cmd == jhep_pkg::CMD_FLUSH) begin
			main_d.cw  = '0;
			main_d.len = '0;
			main_d.flush = 1'b1;
		end
	end

	assign zrl_ent = luma_q ? YAC[jhep_pkg::SYM_ZRL] : CAC[jhep_pkg::SYM_ZRL];

	always_comb begin
		op_valid = busy_q;
		if (zrl_q != 2'd0) begin
			op.cw    = jhep_pkg::CW_W'(zrl_ent.code);
			op.len   = zrl_ent.len;
			op.flush = 1'b0;
			op.last  = 1'b0;
		end else begin
			op = main_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			zrl_q  <= 2'd0;
			pos_q  <= 6'd0;
			zrun_q <= 6'd0;
			for (int i = 0; i < 3; i++)
				pred_q[i] <= '0;
		end else if (accept) begin
			busy_q <= 1'b1;
			main_q <= main_d;
			luma_q <= luma;
			zrl_q  <= 2'd0;
			if (cmd == jhep_pkg::CMD_CODE) begin
				pos_q <= pos_q + 6'd1;
				if (is_dc) begin
					pred_q[comp] <= coefficient;
					zrun_q       <= 6'd0;
				end else if (is_zero) begin
					zrun_q <= (pos_q == 6'd63) ? 6'd0 : zrun_q + 6'd1;
				end else begin
					zrl_q  <= zrun_q[5:4];
					zrun_q <= 6'd0;
				end
			end
		end else if (busy_q && op_ready) begin
			if (zrl_q != 2'd0)
				zrl_q <= zrl_q - 2'd1;
			else
				busy_q <= 1'b0;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/jhep_queue.sv -----
// Small op queue between the front end and the bit packer.
`default_nettype none
module jhep_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          wr_valid,
	output logic               wr_ready,
	input  wire jhep_pkg::op_t wr_op,
	output logic               rd_valid,
	input  wire logic          rd_ready,
	output jhep_pkg::op_t      rd_op
);

	jhep_pkg::op_t                 mem_q [jhep_pkg::QUEUE_DEPTH];
	logic [jhep_pkg::QPTR_W-1:0]   wptr_q;
	logic [jhep_pkg::QPTR_W-1:0]   rptr_q;
	logic [jhep_pkg::QPTR_W:0]     count_q;
	logic                          push;
	logic                          pop;

	assign wr_ready = (count_q != (jhep_pkg::QPTR_W+1)'(jhep_pkg::QUEUE_DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_op    = mem_q[rptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wptr_q] <= wr_op;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wptr_q <= wptr_q + 1'b1;
			if (pop)
				rptr_q <= rptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/jhep_packer.sv -----
// Back end: packs op bit strings into bytes, stuffs zeros and marks last bytes.
`default_nettype none
module jhep_packer (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          op_valid,
	output logic               op_ready,
	input  wire jhep_pkg::op_t op,
	output logic               out_valid,
	input  wire logic          out_ready,
	output logic [7:0]         out_byte,
	output logic               last_byte
);

	logic                         op_v_q;
	logic [jhep_pkg::CW_W-1:0]    cw_q;
	logic [jhep_pkg::LEN_W-1:0]   rem_q;
	logic                         end_q;
	logic [7:0]                   acc_q;
	logic [2:0]                   fill_q;
	logic                         stuff_q;
	logic                         pend_v_q;
	logic [7:0]                   pend_q;
	logic                         out_v_q;
	logic [7:0]                   byte_q;
	logic                         last_q;

	logic                         do_stuff;
	logic                         do_chunk;
	logic                         do_end;
	logic                         do_drop;
	logic                         do_load;
	logic [3:0]                   avail;
	logic [3:0]                   n;
	logic [jhep_pkg::LEN_W-1:0]   sh;
	logic [7:0]                   chunk;
	logic [15:0]                  acc_new;
	logic [3:0]                   fill_new;
	logic                         full;
	logic                         need_out;
	logic                         out_free;
	logic                         stall;

	assign out_valid = out_v_q;
	assign out_byte  = byte_q;
	assign last_byte = last_q;
	assign out_free  = !out_v_q || out_ready;

	always_comb begin
		do_stuff = stuff_q;
		do_chunk = !stuff_q && op_v_q && (rem_q != '0);
		do_end   = !stuff_q && op_v_q && (rem_q == '0) && end_q;
		do_drop  = !stuff_q && op_v_q && (rem_q == '0) && !end_q;
		do_load  = !stuff_q && !op_v_q && op_valid;
		avail    = 4'd8 - {1'b0, fill_q};
		n        = (rem_q < {1'b0, avail}) ? rem_q[3:0] : avail;
		sh       = rem_q - jhep_pkg::LEN_W'(n);
		chunk    = 8'(cw_q >> sh) & 8'((16'd1 << n) - 16'd1);
		acc_new  = ({8'd0, acc_q} << n) | {8'd0, chunk};
		fill_new = {1'b0, fill_q} + n;
		full     = (fill_new == 4'd8);
		need_out = pend_v_q && (do_stuff || (do_chunk && full) || do_end);
		stall    = need_out && !out_free;
		op_ready = do_load;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_v_q   <= 1'b0;
			rem_q    <= '0;
			end_q    <= 1'b0;
			acc_q    <= 8'd0;
			fill_q   <= 3'd0;
			stuff_q  <= 1'b0;
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (need_out && !stall) begin
				out_v_q <= 1'b1;
				byte_q  <= pend_q;
				last_q  <= do_end;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
			if (!stall) begin
				if (do_stuff) begin
					stuff_q  <= 1'b0;
					pend_q   <= jhep_pkg::BYTE_00;
					pend_v_q <= 1'b1;
				end
				if (do_chunk) begin
					rem_q <= sh;
					if (full) begin
						acc_q    <= 8'd0;
						fill_q   <= 3'd0;
						pend_q   <= acc_new[7:0];
						pend_v_q <= 1'b1;
						stuff_q  <= (acc_new[7:0] == jhep_pkg::BYTE_FF);
					end else begin
						acc_q  <= acc_new[7:0];
						fill_q <= fill_new[2:0];
					end
				end
				if (do_end) begin
					pend_v_q <= 1'b0;
					op_v_q   <= 1'b0;
				end
				if (do_drop)
					op_v_q <= 1'b0;
				if (do_load) begin
					op_v_q <= 1'b1;
					end_q  <= op.last;
					if (op.flush) begin
						// Padding with ones completes the partial byte.
						cw_q  <= '1;
						rem_q <= (fill_q == 3'd0) ? '0 : jhep_pkg::LEN_W'(avail);
					end else begin
						cw_q  <= op.cw;
						rem_q <= op.len;
					end
				end
			end
		end
	end

endmodule
`default_nettype wire

// ----- rtl/jpeg_huffman_entropy_packer_unit.sv -----
// Top level of the baseline Huffman entropy packer.
// Input channel (in_valid/in_ready): one beat is a coefficient in zigzag order with its
// component, or a flush command that pads the partial byte with ones. Output channel
// (out_valid/out_ready): one beat is a stream byte; last_byte marks the final byte
// that an input beat causes. Beats that cause no byte produce no output.
// The front end classifies each beat and issues up to three ZRL ops plus one code op
// into a four-entry op queue; it takes a new beat only once all ops of the last beat
// are queued, so beats never overlap in the front end. While the output is not stalled,
// the packer takes up to eight bits per cycle from an op; each op also needs a load
// step and a closing step, and each stuffed zero a step of its own. The last byte of
// a beat is held back until that beat's ops are done so it can be marked.
// Reset clears the DC predictors, block position, zero run and partial byte.
// When the receiver stalls the packer halts, the queue fills and in_ready drops.
`default_nettype none
module jpeg_huffman_entropy_packer_unit #(
	parameter int COEF_WIDTH = 11
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic                  cmd,
	input  wire logic [COEF_WIDTH-1:0] coefficient,
	input  wire logic [1:0]            component,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [7:0]                 out_byte,
	output logic                       last_byte
);

	logic          f_valid;
	logic          f_ready;
	jhep_pkg::op_t f_op;
	logic          b_valid;
	logic          b_ready;
	jhep_pkg::op_t b_op;

	jhep_front #(.COEF_WIDTH(COEF_WIDTH)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.cmd         (cmd),
		.coefficient (coefficient),
		.component   (component),
		.op_valid    (f_valid),
		.op_ready    (f_ready),
		.op          (f_op)
	);

	jhep_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (f_valid),
		.wr_ready (f_ready),
		.wr_op    (f_op),
		.rd_valid (b_valid),
		.rd_ready (b_ready),
		.rd_op    (b_op)
	);

	jhep_packer u_packer (
		.clk       (clk),
		.arst_n    (arst_n),
		.op_valid  (b_valid),
		.op_ready  (b_ready),
		.op        (b_op),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.last_byte (last_byte)
	);

endmodule
`default_nettype wire
